### rtl/ubxd_pkg.sv
// ----------------------------------------------------------------------------
// ubxd_pkg
// Shared types and constants for the UBX frame deframer.
// ----------------------------------------------------------------------------
package ubxd_pkg;

    localparam logic [7:0]  SYNC_FIRST      = 8'hB5;
    localparam logic [7:0]  SYNC_SECOND     = 8'h62;
    localparam logic [15:0] MAX_PAYLOAD_RST = 16'd100;

    typedef enum logic [2:0] {
        PH_SYNC1   = 3'd0,
        PH_SYNC2   = 3'd1,
        PH_HEADER  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CKA     = 3'd4,
        PH_CKB     = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        EV_SKIP    = 3'd0,
        EV_HEADER  = 3'd1,
        EV_PAYLOAD = 3'd2,
        EV_GOOD    = 3'd3,
        EV_BAD     = 3'd4,
        EV_TOOLONG = 3'd5
    } event_t;

    typedef enum logic [1:0] {
        HDR_CLASS  = 2'd0,
        HDR_ID     = 2'd1,
        HDR_LEN_LO = 2'd2,
        HDR_LEN_HI = 2'd3
    } hdr_pos_t;

    // Byte held in the input register
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } item_t;

endpackage

### rtl/ubxd_in_reg.sv
// ----------------------------------------------------------------------------
// ubxd_in_reg
// Input register: holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module ubxd_in_reg
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic [7:0]     in_byte,
    input  logic           take,
    output ubxd_pkg::item_t item
);
    import ubxd_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       accept;

    assign in_stall   = valid_reg && !take;
    assign accept     = in_valid && !in_stall;
    assign valid_next = accept || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= in_byte;
        end
    end

    assign item.valid = valid_reg;
    assign item.data  = data_reg;

endmodule

### rtl/ubxd_parser.sv
// ----------------------------------------------------------------------------
// ubxd_parser
// Frame state machine, Fletcher-8 sums and the result register.
// ----------------------------------------------------------------------------
module ubxd_parser
(
    input  logic            clk,
    input  logic            rst_n,
    input  ubxd_pkg::item_t item,
    output logic            take,
    input  logic            max_payload_we,
    input  logic [15:0]     max_payload,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [2:0]      event_kind,
    output logic [7:0]      data_byte,
    output logic [15:0]     payload_offset,
    output logic [7:0]      message_class,
    output logic [7:0]      message_id,
    output logic [15:0]     payload_length
);
    import ubxd_pkg::*;

    logic [15:0] max_payload_reg;
    phase_t      phase_reg,        phase_next;
    logic [7:0]  sum_a_reg,        sum_a_next;
    logic [7:0]  sum_b_reg,        sum_b_next;
    logic [15:0] frame_length_reg, frame_length_next;
    logic [15:0] byte_count_reg,   byte_count_next;
    logic [7:0]  held_class_reg,   held_class_next;
    logic [7:0]  held_id_reg,      held_id_next;
    logic [7:0]  first_check_reg,  first_check_next;

    logic        out_valid_reg,    out_valid_next;
    event_t      event_reg,        event_next;
    logic [7:0]  data_reg;
    logic [15:0] offset_reg,       offset_next;
    logic [7:0]  class_reg;
    logic [7:0]  id_reg;
    logic [15:0] length_reg;

    logic        fire;
    logic [7:0]  b;
    logic [7:0]  sum_a_add;
    logic [7:0]  sum_b_add;
    logic [15:0] full_len;
    logic [15:0] count_inc;

    assign take           = !out_valid_reg || !out_stall;
    assign fire           = item.valid && take;
    assign b              = item.data;
    assign sum_a_add      = sum_a_reg + b;
    assign sum_b_add      = sum_b_reg + sum_a_add;
    assign full_len       = frame_length_reg | {b, 8'h00};
    assign count_inc      = byte_count_reg + 16'd1;
    assign out_valid_next = fire || (out_valid_reg && out_stall);

    always_comb
    begin
        phase_next        = phase_reg;
        sum_a_next        = sum_a_reg;
        sum_b_next        = sum_b_reg;
        frame_length_next = frame_length_reg;
        byte_count_next   = byte_count_reg;
        held_class_next   = held_class_reg;
        held_id_next      = held_id_reg;
        first_check_next  = first_check_reg;
        event_next        = EV_SKIP;
        offset_next       = 16'd0;
        case (phase_reg)
            PH_SYNC2:
            begin
                if (b == SYNC_SECOND)
                begin
                    phase_next        = PH_HEADER;
                    sum_a_next        = 8'd0;
                    sum_b_next        = 8'd0;
                    byte_count_next   = 16'd0;
                    held_class_next   = 8'd0;
                    held_id_next      = 8'd0;
                    frame_length_next = 16'd0;
                    event_next        = EV_HEADER;
                end
                else if (b == SYNC_FIRST)
                begin
                    event_next = EV_HEADER;
                end
                else
                begin
                    phase_next = PH_SYNC1;
                end
            end
            PH_HEADER:
            begin
                sum_a_next = sum_a_add;
                sum_b_next = sum_b_add;
                event_next = EV_HEADER;
                if (byte_count_reg == 16'(HDR_CLASS))
                begin
                    held_class_next = b;
                    byte_count_next = 16'(HDR_ID);
                end
                else if (byte_count_reg == 16'(HDR_ID))
                begin
                    held_id_next    = b;
                    byte_count_next = 16'(HDR_LEN_LO);
                end
                else if (byte_count_reg == 16'(HDR_LEN_LO))
                begin
                    frame_length_next = {8'h00, b};
                    byte_count_next   = 16'(HDR_LEN_HI);
                end
                else
                begin
                    frame_length_next = full_len;
                    byte_count_next   = 16'd0;
                    if (full_len > max_payload_reg)
                    begin
                        event_next = EV_TOOLONG;
                        phase_next = PH_SYNC1;
                    end
                    else if (full_len == 16'd0)
                    begin
                        phase_next = PH_CKA;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                sum_a_next      = sum_a_add;
                sum_b_next      = sum_b_add;
                event_next      = EV_PAYLOAD;
                offset_next     = byte_count_reg;
                byte_count_next = count_inc;
                if (count_inc >= frame_length_reg)
                begin
                    phase_next = PH_CKA;
                end
            end
            PH_CKA:
            begin
                first_check_next = b;
                event_next       = EV_HEADER;
                phase_next       = PH_CKB;
            end
            PH_CKB:
            begin
                if (first_check_reg == sum_a_reg && b == sum_b_reg)
                begin
                    event_next = EV_GOOD;
                end
                else
                begin
                    event_next = EV_BAD;
                end
                phase_next = PH_SYNC1;
            end
            default:
            begin
                phase_next = PH_SYNC1;
                if (b == SYNC_FIRST)
                begin
                    phase_next = PH_SYNC2;
                    event_next = EV_HEADER;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg  <= MAX_PAYLOAD_RST;
            phase_reg        <= PH_SYNC1;
            sum_a_reg        <= 8'd0;
            sum_b_reg        <= 8'd0;
            frame_length_reg <= 16'd0;
            byte_count_reg   <= 16'd0;
            held_class_reg   <= 8'd0;
            held_id_reg      <= 8'd0;
            first_check_reg  <= 8'd0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (max_payload_we)
            begin
                max_payload_reg <= max_payload;
            end
            if (fire)
            begin
                phase_reg        <= phase_next;
                sum_a_reg        <= sum_a_next;
                sum_b_reg        <= sum_b_next;
                frame_length_reg <= frame_length_next;
                byte_count_reg   <= byte_count_next;
                held_class_reg   <= held_class_next;
                held_id_reg      <= held_id_next;
                first_check_reg  <= first_check_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            event_reg  <= event_next;
            data_reg   <= b;
            offset_reg <= offset_next;
            class_reg  <= held_class_next;
            id_reg     <= held_id_next;
            length_reg <= frame_length_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign event_kind     = event_reg;
    assign data_byte      = data_reg;
    assign payload_offset = offset_reg;
    assign message_class  = class_reg;
    assign message_id     = id_reg;
    assign payload_length = length_reg;

endmodule

### rtl/ubx_frame_deframer.sv
// ----------------------------------------------------------------------------
// ubx_frame_deframer
// UBX deframer: sync hunt, header decode, payload tagging, Fletcher-8 check.
// ----------------------------------------------------------------------------
//  channel  | signals                                  | transfer when
//  ---------+------------------------------------------+---------------------
//  in       | in_valid, in_stall, in_byte              | in_valid & !in_stall
//  out      | out_valid, out_stall, event_kind ..      | out_valid & !out_stall
//           |   payload_length                         |
//  cfg      | max_payload_we, max_payload              | max_payload_we
//
// One byte per cycle sustained while out_stall is low; each byte passes the
// input register, then parser logic into the result register.
// Reset: hunting for the first sync byte, max_payload = 100.
// out_stall holds the result register; an empty input register still takes
// one more byte, a full one raises in_stall in the same cycle.
// ----------------------------------------------------------------------------
module ubx_frame_deframer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        max_payload_we,
    input  logic [15:0] max_payload,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  event_kind,
    output logic [7:0]  data_byte,
    output logic [15:0] payload_offset,
    output logic [7:0]  message_class,
    output logic [7:0]  message_id,
    output logic [15:0] payload_length
);
    import ubxd_pkg::*;

    item_t item;
    logic  take;

    ubxd_in_reg u_in_reg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_byte  (in_byte),
        .take     (take),
        .item     (item)
    );

    ubxd_parser u_parser
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .item           (item),
        .take           (take),
        .max_payload_we (max_payload_we),
        .max_payload    (max_payload),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .event_kind     (event_kind),
        .data_byte      (data_byte),
        .payload_offset (payload_offset),
        .message_class  (message_class),
        .message_id     (message_id),
        .payload_length (payload_length)
    );

endmodule

### rtl/ubxd_checker.sv
// ----------------------------------------------------------------------------
// ubxd_checker
// Port-level checks for the UBX deframer, bound to the top level.
// ----------------------------------------------------------------------------
module ubxd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [7:0]  in_byte,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  event_kind,
    input logic [7:0]  data_byte,
    input logic [15:0] payload_offset,
    input logic [7:0]  message_class,
    input logic [7:0]  message_id,
    input logic [15:0] payload_length
);
    import ubxd_pkg::*;

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_byte))
        else $error("input transfer changed while stalled");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out_valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(event_kind) && $stable(data_byte)
            && $stable(payload_offset) && $stable(payload_length)
            && $stable(message_class) && $stable(message_id))
        else $error("result changed while stalled");

    a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind != EV_PAYLOAD |-> payload_offset == 16'd0)
        else $error("nonzero offset outside payload");

    a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind == EV_PAYLOAD |-> payload_offset < payload_length)
        else $error("payload offset beyond length");

endmodule

bind ubx_frame_deframer ubxd_checker u_ubxd_checker (.*);
